// File: hdl/fprc_pkg.sv
`timescale 1ns / 1ps

package fprc_pkg;

  localparam int unsigned ROM_ADDR_W = 16;
  localparam int unsigned ROM_WORDS  = 65536;
  localparam int unsigned CFG_W      = 5;

  typedef enum logic [2:0] {
    REQ_DISK_WRITE = 3'd0,
    REQ_PORT_A     = 3'd1,
    REQ_SELECT     = 3'd2,
    REQ_STATUS     = 3'd3,
    REQ_ROM_LOAD   = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    PICK_EVEN = 2'd0,
    PICK_ODD  = 2'd1,
    PICK_NONE = 2'd2
  } pick_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] write_word;
    logic [7:0]  port_output;
    logic [7:0]  port_direction;
    logic [7:0]  select_value;
    logic [7:0]  select_previous;
    logic [1:0]  drive_number;
    logic [7:0]  status_in;
    logic [16:0] rom_byte_index;
    logic [7:0]  rom_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] status_out;
    logic       active;
  } out_item_t;

  // Port A bits
  localparam int unsigned PA_CHNG = 2;
  localparam int unsigned PA_TK0  = 3;
  localparam int unsigned PA_WPRO = 4;
  // Drive register DIR bit
  localparam int unsigned DRV_DIR = 1;
  // Status bit carrying the data MSB
  localparam int unsigned ST_DATA = 5;

  // Counter bit i lands on ROM address bit ADDR_PERM[i]
  localparam logic [3:0] ADDR_PERM [16] = '{
    4'd14, 4'd12, 4'd2, 4'd10, 4'd15, 4'd13, 4'd1, 4'd0,
    4'd7, 4'd6, 4'd5, 4'd4, 4'd8, 4'd9, 4'd11, 4'd3
  };

  // Output bit i takes raw ROM bit DATA_PERM[i]
  localparam logic [2:0] DATA_PERM [8] = '{
    3'd3, 3'd2, 3'd4, 3'd5, 3'd7, 3'd6, 3'd0, 3'd1
  };

  function automatic logic [ROM_ADDR_W-1:0] rom_addr_map(input logic [ROM_ADDR_W-1:0] cnt);
    logic [ROM_ADDR_W-1:0] a;
    a = '0;
    for (int i = 0; i < 16; i++) begin
      a[ADDR_PERM[i]] = cnt[i];
    end
    return a;
  endfunction

  function automatic logic [7:0] rom_data_map(input logic [7:0] raw);
    logic [7:0] v;
    v = '0;
    for (int i = 0; i < 8; i++) begin
      v[i] = raw[DATA_PERM[i]];
    end
    return v;
  endfunction

  // Count of one-to-zero steps in a 16-bit stream, given the bit before it
  function automatic logic [4:0] fall_count(input logic last, input logic [15:0] w);
    logic [15:0] falls;
    logic [4:0]  n;
    falls = {last, w[15:1]} & ~w;
    n = '0;
    for (int i = 0; i < 16; i++) begin
      n = n + 5'(falls[i]);
    end
    return n;
  endfunction

endpackage

// File: hdl/floppy_port_rom_cartridge.sv
`timescale 1ns / 1ps

// Latency: the result of an item is presented on the cycle after it is accepted.
// Throughput: one item per cycle unless the output stalls; a select edge reads the
// ROM memories, and the byte arrives next cycle, forwarded to the item that follows.
// Reset: control state, counter and shift register return to their idle values;
// the ROM memories are not cleared and hold nothing until loaded.
module floppy_port_rom_cartridge #(
  parameter int unsigned COUNTER_WIDTH = 18
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  fprc_pkg::in_item_t       in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output fprc_pkg::out_item_t      out_item_o,
  input  logic                     cfg_we_i,
  input  logic [fprc_pkg::CFG_W-1:0] cfg_wdata_i
);
  import fprc_pkg::*;

  localparam logic [CFG_W-1:0] CW_MAX = CFG_W'(COUNTER_WIDTH);

  // ROM lanes: even byte is the high half of a word
  logic [7:0] rom_even_mem [ROM_WORDS];
  logic [7:0] rom_odd_mem  [ROM_WORDS];

  logic [CFG_W-1:0]         cfg_bits_q;
  logic [COUNTER_WIDTH-1:0] counter_q, counter_d;
  logic                     last_bit_q, last_bit_d;
  logic [7:0]               shift_q, shift_d;
  pick_e                    pick_q, pick_d;
  logic [7:0]               prev_port_q, prev_port_d;
  logic [7:0]               drive_q, drive_d;
  logic                     active_q, active_d;
  logic                     pend_q, pend_d;
  logic                     lane_q, lane_d;
  logic                     out_valid_q, out_valid_d;
  out_item_t                out_q, out_d;

  logic [7:0]               rd_even_q, rd_odd_q;
  logic                     rd_en;
  logic [ROM_ADDR_W-1:0]    rd_addr;
  logic                     wr_even, wr_odd;
  logic [ROM_ADDR_W-1:0]    wr_addr;

  logic                     accept;
  logic [7:0]               shift_cur;
  logic [CFG_W-1:0]         mask_n;
  logic [COUNTER_WIDTH-1:0] cnt_mask;
  logic [7:0]               port_v;
  logic [2:0]               sel_idx;
  logic                     dir_clr;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Byte fetched last cycle overrides the stored shift register
  assign shift_cur = pend_q ? rom_data_map(lane_q ? rd_odd_q : rd_even_q) : shift_q;

  assign mask_n   = (cfg_bits_q > CW_MAX) ? CW_MAX : cfg_bits_q;
  assign cnt_mask = ~({COUNTER_WIDTH{1'b1}} << mask_n);
  assign port_v   = in_item_i.port_output & in_item_i.port_direction;
  assign sel_idx  = 3'(in_item_i.drive_number) + 3'd3;
  assign rd_addr  = rom_addr_map(counter_q[ROM_ADDR_W-1:0]);
  assign wr_addr  = in_item_i.rom_byte_index[ROM_ADDR_W:1];

  always_comb begin
    counter_d   = counter_q;
    last_bit_d  = last_bit_q;
    shift_d     = shift_cur;
    pick_d      = pick_q;
    prev_port_d = prev_port_q;
    drive_d     = drive_q;
    active_d    = active_q;
    pend_d      = 1'b0;
    lane_d      = lane_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    rd_en       = 1'b0;
    wr_even     = 1'b0;
    wr_odd      = 1'b0;
    dir_clr     = 1'b0;

    if (accept) begin
      out_d.status_out = '0;
      unique case (req_e'(in_item_i.req_type))
        REQ_DISK_WRITE: begin
          counter_d  = (counter_q
                        + COUNTER_WIDTH'(fall_count(last_bit_q, in_item_i.write_word)))
                       & cnt_mask;
          last_bit_d = in_item_i.write_word[0];
          dir_clr    = drive_q[DRV_DIR];
        end
        REQ_PORT_A: begin
          if (port_v[PA_CHNG] && !prev_port_q[PA_CHNG]) begin
            shift_d = {shift_cur[6:0], 1'b1};
          end
          if (port_v[PA_TK0] && port_v[PA_WPRO]) begin
            pick_d = PICK_NONE;
          end else begin
            pick_d = port_v[PA_WPRO] ? PICK_EVEN : PICK_ODD;
          end
          prev_port_d = port_v;
          dir_clr     = drive_q[DRV_DIR];
        end
        REQ_SELECT: begin
          drive_d = in_item_i.select_value;
          if (!in_item_i.select_value[sel_idx] && in_item_i.select_previous[sel_idx]) begin
            active_d = 1'b1;
            if (pick_q == PICK_NONE) begin
              shift_d = 8'hFF;
            end else begin
              // fetch now, byte lands next cycle
              rd_en  = 1'b1;
              pend_d = 1'b1;
              lane_d = (pick_q == PICK_ODD);
            end
          end
          dir_clr = in_item_i.select_value[DRV_DIR];
        end
        REQ_STATUS: begin
          out_d.status_out = in_item_i.status_in;
          if (!shift_cur[7]) begin
            out_d.status_out[ST_DATA] = 1'b0;
          end
        end
        REQ_ROM_LOAD: begin
          wr_even = !in_item_i.rom_byte_index[0];
          wr_odd  = in_item_i.rom_byte_index[0];
        end
        default: begin
        end
      endcase
      if (dir_clr) begin
        counter_d = '0;
        active_d  = 1'b0;
      end
      out_d.active = active_d;
      out_valid_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_even) begin
      rom_even_mem[wr_addr] <= in_item_i.rom_byte;
    end
    if (rd_en) begin
      rd_even_q <= rom_even_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_odd) begin
      rom_odd_mem[wr_addr] <= in_item_i.rom_byte;
    end
    if (rd_en) begin
      rd_odd_q <= rom_odd_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_bits_q  <= CFG_W'(18);
      counter_q   <= '0;
      last_bit_q  <= 1'b0;
      shift_q     <= 8'hFF;
      pick_q      <= PICK_EVEN;
      prev_port_q <= '0;
      drive_q     <= '0;
      active_q    <= 1'b0;
      pend_q      <= 1'b0;
      lane_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_bits_q <= cfg_wdata_i;
      end
      counter_q   <= counter_d;
      last_bit_q  <= last_bit_d;
      shift_q     <= shift_d;
      pick_q      <= pick_d;
      prev_port_q <= prev_port_d;
      drive_q     <= drive_d;
      active_q    <= active_d;
      pend_q      <= pend_d;
      lane_q      <= lane_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

// File: hdl/fprc_checker.sv
`timescale 1ns / 1ps

module fprc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input fprc_pkg::in_item_t         in_item_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input fprc_pkg::out_item_t        out_item_o,
  input logic                       cfg_we_i,
  input logic [fprc_pkg::CFG_W-1:0] cfg_wdata_i
);
  import fprc_pkg::*;

  logic acc;
  assign acc = in_valid_i && !in_stall_o;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled result changed");

  // Every accepted item gives a result next cycle
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> out_valid_o)
    else $error("accepted item gave no result");

  // Only status reads carry a status byte
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_item_i.req_type != REQ_STATUS) |=> (out_item_o.status_out == 8'h00))
    else $error("status byte on a non-status item");

  // Status read touches bit 5 only
  a_status_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_item_i.req_type == REQ_STATUS) |=>
      ((out_item_o.status_out & 8'hDF) == ($past(in_item_i.status_in) & 8'hDF)))
    else $error("status read altered other bits");

  // DIR set in a drive select write drops the active flag
  a_dir_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_item_i.req_type == REQ_SELECT && in_item_i.select_value[DRV_DIR])
      |=> !out_item_o.active)
    else $error("active flag survived DIR");

endmodule

bind floppy_port_rom_cartridge fprc_checker u_fprc_checker (.*);

// File: bench/tb_floppy_port_rom_cartridge.sv
`timescale 1ns / 1ps

module tb_floppy_port_rom_cartridge;
  import fprc_pkg::*;

  localparam int CTR_W = 18;
  // counter bit i -> ROM address bit, element i at [i*4 +: 4]
  localparam logic [63:0] ADDR_MAP = {4'd3, 4'd11, 4'd9, 4'd8, 4'd4, 4'd5, 4'd6, 4'd7,
                                      4'd0, 4'd1, 4'd13, 4'd15, 4'd10, 4'd2, 4'd12, 4'd14};
  // output bit i <- raw ROM bit, element i at [i*3 +: 3]
  localparam logic [23:0] DATA_MAP = {3'd1, 3'd0, 3'd6, 3'd7, 3'd5, 3'd4, 3'd2, 3'd3};

  typedef struct packed {
    logic [4:0]       cnt_bits;
    logic [CTR_W-1:0] addr_cnt;
    logic             last_bit;
    logic [7:0]       shifter;
    pick_e            pick;
    logic [7:0]       prev_port;
    logic [7:0]       drive_reg;
    logic             active;
  } cart_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_item_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_item_o;
  logic        cfg_we_i = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  in_item_t    pending_reqs[$];
  out_item_t   awaited_replies[$];
  cart_t       shadow_cart;
  cart_t       plan_cart;
  logic [7:0]  rom_bytes [0:131071];
  bit          rom_known [0:131071];
  bit          calm = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned stall_span;
  int unsigned planned = 0;
  int unsigned sent = 0;
  int unsigned checked = 0;
  int unsigned latches = 0;
  int unsigned widths_used = 1;
  int unsigned faults = 0;

  floppy_port_rom_cartridge #(.COUNTER_WIDTH(CTR_W)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic cart_t cart_reset();
    cart_t s;
    s = '0;
    s.cnt_bits = 5'd18;
    s.shifter = 8'hFF;
    s.pick = PICK_EVEN;
    return s;
  endfunction

  function automatic logic sel_falls(input in_item_t it);
    return it.req_type == REQ_SELECT && !it.select_value[3 + it.drive_number]
           && it.select_previous[3 + it.drive_number];
  endfunction

  // byte index of the ROM byte a select edge would latch now
  function automatic logic [16:0] latch_slot(input cart_t s);
    logic [15:0] w;
    w = '0;
    for (int i = 0; i < 16; i++) w[ADDR_MAP[i*4 +: 4]] = s.addr_cnt[i];
    return {w, s.pick == PICK_ODD};
  endfunction

  function automatic cart_t cart_next(input cart_t s, input in_item_t it,
                                      input logic [7:0] rom_val);
    logic [CTR_W:0] mask;
    logic [7:0] v;
    int unsigned n;
    if (it.req_type == REQ_DISK_WRITE) begin
      for (int i = 15; i >= 0; i--) begin
        if (s.last_bit && !it.write_word[i]) s.addr_cnt = s.addr_cnt + 1'b1;
        s.last_bit = it.write_word[i];
      end
      n = (s.cnt_bits > CTR_W) ? CTR_W : s.cnt_bits;
      mask = ((CTR_W+1)'(1) << n) - 1'b1;
      s.addr_cnt = s.addr_cnt & mask[CTR_W-1:0];
    end else if (it.req_type == REQ_PORT_A) begin
      v = it.port_output & it.port_direction;
      if (v[PA_CHNG] && !s.prev_port[PA_CHNG]) s.shifter = {s.shifter[6:0], 1'b1};
      if (v[PA_TK0] && v[PA_WPRO]) s.pick = PICK_NONE;
      else s.pick = v[PA_WPRO] ? PICK_EVEN : PICK_ODD;
      s.prev_port = v;
    end else if (it.req_type == REQ_SELECT) begin
      s.drive_reg = it.select_value;
      if (sel_falls(it)) begin
        s.active = 1'b1;
        if (s.pick == PICK_NONE) begin
          s.shifter = 8'hFF;
        end else begin
          for (int i = 0; i < 8; i++) s.shifter[i] = rom_val[DATA_MAP[i*3 +: 3]];
        end
      end
    end
    if (it.req_type inside {REQ_DISK_WRITE, REQ_PORT_A, REQ_SELECT} && s.drive_reg[DRV_DIR])
    begin
      s.addr_cnt = '0;
      s.active = 1'b0;
    end
    return s;
  endfunction

  function automatic out_item_t cart_reply(input cart_t s, input in_item_t it);
    out_item_t r;
    r.status_out = 8'h00;
    if (it.req_type == REQ_STATUS) begin
      r.status_out = it.status_in;
      if (!s.shifter[7]) r.status_out[ST_DATA] = 1'b0;
    end
    r.active = s.active;
    return r;
  endfunction

  function automatic int unsigned idle_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic in_item_t noise_item(input logic [2:0] kind);
    in_item_t it;
    it.req_type        = kind;
    it.write_word      = 16'($urandom);
    it.port_output     = 8'($urandom);
    it.port_direction  = 8'($urandom);
    it.select_value    = 8'($urandom);
    it.select_previous = 8'($urandom);
    it.drive_number    = 2'($urandom);
    it.status_in       = 8'($urandom);
    it.rom_byte_index  = 17'($urandom);
    it.rom_byte        = 8'($urandom);
    return it;
  endfunction

  // random output/direction pair whose AND carries the given CHNG, TK0 and WPRO
  function automatic in_item_t port_item(input logic chng, input logic tk0, input logic wpro);
    in_item_t it;
    logic [7:0] v;
    logic [7:0] d;
    it = noise_item(REQ_PORT_A);
    v = (8'($urandom) & 8'hE3) | {3'b000, wpro, tk0, chng, 2'b00};
    d = 8'($urandom) | v;
    it.port_direction = d;
    it.port_output = v | (8'($urandom) & ~d);
    return it;
  endfunction

  function automatic in_item_t select_item(input logic [1:0] dn, input logic fall,
                                           input logic dir_set);
    in_item_t it;
    it = noise_item(REQ_SELECT);
    it.drive_number = dn;
    if (fall) begin
      it.select_previous[3 + dn] = 1'b1;
      it.select_value[3 + dn] = 1'b0;
    end
    it.select_value[DRV_DIR] = dir_set;
    return it;
  endfunction

  // load the byte a latching select would read first, if nothing has been stored there
  task automatic queue_req(input in_item_t it);
    in_item_t fill;
    logic [16:0] slot;
    slot = latch_slot(plan_cart);
    if (sel_falls(it) && plan_cart.pick != PICK_NONE && !rom_known[slot]) begin
      fill = noise_item(REQ_ROM_LOAD);
      fill.rom_byte_index = slot;
      rom_known[slot] = 1'b1;
      pending_reqs.push_back(fill);
      planned++;
    end
    if (it.req_type == REQ_ROM_LOAD) rom_known[it.rom_byte_index] = 1'b1;
    plan_cart = cart_next(plan_cart, it, 8'h00);
    pending_reqs.push_back(it);
    planned++;
  endtask

  task automatic report_fault(input string msg);
    faults++;
    if (faults <= 40) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic drain();
    @(negedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || awaited_replies.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_width(input logic [4:0] bits);
    drain();
    repeat (2) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= bits;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_cart.cnt_bits = bits;
    plan_cart.cnt_bits = bits;
    widths_used++;
  endtask

  task automatic random_phase(input int unsigned count);
    int unsigned start;
    int unsigned r;
    logic tk0;
    logic wpro;
    start = planned;
    while (planned - start < count) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        // readout: step the counter, pick a byte, latch it, clock it out
        repeat ($urandom_range(1, 3)) queue_req(noise_item(REQ_DISK_WRITE));
        r = $urandom_range(0, 9);
        wpro = (r < 5);
        tk0 = (r == 0) || (r >= 5 && $urandom_range(0, 1) == 1);
        queue_req(port_item(1'b0, tk0, wpro));
        queue_req(select_item(2'($urandom), 1'b1, $urandom_range(0, 7) == 0));
        repeat ($urandom_range(1, 9)) begin
          queue_req(port_item(1'b0, tk0, wpro));
          queue_req(port_item(1'b1, tk0, wpro));
          queue_req(noise_item(REQ_STATUS));
        end
      end else if (r < 72) begin
        repeat ($urandom_range(1, 4)) queue_req(noise_item(REQ_ROM_LOAD));
      end else begin
        repeat ($urandom_range(1, 3)) queue_req(noise_item(3'($urandom_range(0, 7))));
      end
    end
  endtask

  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) calm <= ~calm;
  end

  always @(posedge clk_i or negedge rst_ni) begin : drive_req
    logic [7:0] rom_val;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        if (in_item_i.req_type == REQ_ROM_LOAD)
          rom_bytes[in_item_i.rom_byte_index] = in_item_i.rom_byte;
        if (sel_falls(in_item_i)) latches++;
        rom_val = rom_bytes[latch_slot(shadow_cart)];
        shadow_cart = cart_next(shadow_cart, in_item_i, rom_val);
        awaited_replies.push_back(cart_reply(shadow_cart, in_item_i));
        sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          in_item_i <= pending_reqs.pop_front();
          in_valid_i <= 1'b1;
          gap_left <= idle_span();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_span = idle_span();
      out_stall_i <= (stall_span != 0);
      stall_left <= stall_span;
    end
  end

  always @(posedge clk_i) begin : check_reply
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_replies.size() == 0) begin
        report_fault($sformatf("reply %h with nothing outstanding", out_item_o));
      end else begin
        want = awaited_replies.pop_front();
        if (out_item_o.status_out !== want.status_out)
          report_fault($sformatf("reply %0d status_out %h, want %h", checked,
                                 out_item_o.status_out, want.status_out));
        if (out_item_o.active !== want.active)
          report_fault($sformatf("reply %0d active %b, want %b", checked,
                                 out_item_o.active, want.active));
        checked++;
      end
    end
  end

  initial begin
    #8_000_000;
    $display("floppy_port_rom_cartridge verification failed");
    $finish;
  end

  initial begin : run
    logic [4:0] widths [7];
    in_item_t it;
    shadow_cart = cart_reset();
    plan_cart = cart_reset();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // status with the reset data register, then the extremes of the write stream
    it = noise_item(REQ_STATUS);
    it.status_in = 8'hFF;
    queue_req(it);
    it.status_in = 8'h00;
    queue_req(it);
    it = noise_item(REQ_DISK_WRITE);
    it.write_word = 16'hFFFF;
    queue_req(it);
    it.write_word = 16'h0000;
    queue_req(it);
    it.write_word = 16'hAAAA;
    queue_req(it);
    it.write_word = 16'h5555;
    queue_req(it);
    // port A extremes: all ones gives no byte picked, all zeros the odd byte
    it = noise_item(REQ_PORT_A);
    it.port_output = 8'hFF;
    it.port_direction = 8'hFF;
    queue_req(it);
    it.port_output = 8'h00;
    it.port_direction = 8'h00;
    queue_req(it);
    queue_req(port_item(1'b1, 1'b0, 1'b1));
    // a latch on every drive line
    for (int d = 0; d < 4; d++) queue_req(select_item(2'(d), 1'b1, 1'b0));
    queue_req(noise_item(REQ_STATUS));
    // no byte picked latches all ones
    queue_req(port_item(1'b0, 1'b1, 1'b1));
    queue_req(select_item(2'd0, 1'b1, 1'b0));
    queue_req(noise_item(REQ_STATUS));
    // DIR set clears counter and active flag
    queue_req(select_item(2'd2, 1'b0, 1'b1));
    it = noise_item(REQ_ROM_LOAD);
    it.rom_byte_index = 17'd0;
    it.rom_byte = 8'hFF;
    queue_req(it);
    it.rom_byte_index = 17'h1FFFF;
    it.rom_byte = 8'h00;
    queue_req(it);
    for (int k = 5; k < 8; k++) queue_req(noise_item(3'(k)));

    random_phase(78);
    widths = '{5'd1, 5'd31, 5'd0, 5'd18, 5'd17, 5'd16, 5'd9};
    widths[6] = 5'($urandom_range(2, 15));
    foreach (widths[p]) begin
      write_width(widths[p]);
      random_phase(78);
    end

    drain();
    repeat (4) @(posedge clk_i);
    $display("%0d requests driven and %0d replies compared over %0d counter widths",
             sent, checked, widths_used);
    $display("%0d select edges latched a ROM byte or the all-ones default", latches);
    if (faults == 0) begin
      $display("floppy_port_rom_cartridge verification clean");
    end else begin
      $display("floppy_port_rom_cartridge verification failed");
    end
    $finish;
  end

endmodule
